// ===== hw/rtl/fsrr_pkg.sv =====
// ----------------------------------------------------------------------------
// fsrr_pkg
// Shared widths, constants, state codes and the command and status structs
// of the fixation-scaled rate row block.
// ----------------------------------------------------------------------------
package fsrr_pkg;

  // field and datapath widths
  localparam int RATE_W   = 32;  // unsigned Q16.16 base rate
  localparam int FIT_W    = 24;  // signed Q7.16 fitness
  localparam int CFIT_W   = 22;  // clamped fitness, +-20 in Q16
  localparam int S_W      = 23;  // fitness difference
  localparam int X_W      = 22;  // magnitude of the difference
  localparam int OUT_W    = 48;  // signed Q31.16 result
  localparam int E_W      = 40;  // scaled entry, never negative
  localparam int SUM_W    = 48;  // saturating row sum
  localparam int G_W      = 32;  // fixation factor, unsigned Q24
  localparam int Q32_W    = 33;  // Q32 value that may reach one
  localparam int F_W      = 32;  // fraction in Q32
  localparam int MUL_W    = 33;  // multiplier operand
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DVD_W    = 64;  // divider dividend and quotient
  localparam int DVS_W    = 33;  // divider divisor
  localparam int K_W      = 7;   // integer part of x*log2(e)
  localparam int STEP_W   = 7;   // divider step count
  localparam int N_W      = 4;   // series term index
  localparam int ACC_W    = 35;  // signed series accumulator
  localparam int RSH_W    = 6;   // reciprocal product shift

  // arithmetic constants
  localparam logic signed [CFIT_W-1:0] FIT_LIMIT = 22'sd1310720;
  localparam logic signed [S_W-1:0]    SMALL_S   = 23'sd6;
  localparam logic [MUL_W-1:0]  LOG2E_Q30 = 33'd1549082005;
  localparam logic [MUL_W-1:0]  LN2_Q32   = 33'd2977044472;
  localparam logic [Q32_W-1:0]  ONE_Q32   = 33'h1_0000_0000;
  localparam logic [G_W-1:0]    ONE_Q24   = 32'h0100_0000;
  localparam logic [PROD_W-1:0] ROUND_Q24 = 66'h80_0000;
  localparam logic [SUM_W-1:0]  SUM_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [N_W-1:0]    N_TERMS   = 4'd11;
  localparam logic [STEP_W-1:0] G_STEPS    = 7'd62;
  localparam logic [K_W-1:0]    K_ZERO     = 7'd33;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_YMUL,
    ST_YGET,
    ST_ZMUL,
    ST_ZGET,
    ST_TMUL,
    ST_TREC,
    ST_TGET,
    ST_UCALC,
    ST_XUMUL,
    ST_GDIV,
    ST_GWAIT,
    ST_RMUL,
    ST_EGET,
    ST_EMIT_E,
    ST_EMIT_D
  } state_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_X_LOG2E,
    MUL_F_LN2,
    MUL_T_Z,
    MUL_T_RECIP,
    MUL_X_U,
    MUL_R_G
  } mul_sel_t;

  // divider jobs
  typedef enum logic [1:0] {
    DIV_POS,
    DIV_NEG
  } div_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      ld_in;
    logic      ld_diff;
    logic      ld_yk;
    logic      ld_z;
    logic      div_go;
    div_kind_t div_kind;
    logic      ld_term;
    logic      ld_u;
    logic      ld_g;
    logic      ld_e;
    logic      emit_e;
    logic      emit_d;
    mul_sel_t  mul_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic near_zero;
    logic s_pos;
    logic n_last;
    logic row_end;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/fsrr_mul.sv =====
// ----------------------------------------------------------------------------
// fsrr_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module fsrr_mul (
  input  logic                          clk,
  input  logic [fsrr_pkg::MUL_W-1:0]    a,
  input  logic [fsrr_pkg::MUL_W-1:0]    b,
  output logic [fsrr_pkg::PROD_W-1:0]   prod_r
);

  // product register
  always_ff @(posedge clk) begin
    prod_r <= fsrr_pkg::PROD_W'(a) * fsrr_pkg::PROD_W'(b);
  end

endmodule

// ===== hw/rtl/fsrr_div.sv =====
// ----------------------------------------------------------------------------
// fsrr_div
// Bit-serial restoring divider, one quotient bit per cycle. The dividend
// comes in aligned to the top bit; after the given number of steps the
// quotient sits in the low bits.
// ----------------------------------------------------------------------------
module fsrr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fsrr_pkg::DVD_W-1:0]    dividend,
  input  logic [fsrr_pkg::DVS_W-1:0]    divisor,
  input  logic [fsrr_pkg::STEP_W-1:0]   steps,
  output logic                          busy,
  output logic [fsrr_pkg::DVD_W-1:0]    quotient
);

  logic [fsrr_pkg::DVD_W-1:0]  q_r, q_nxt;
  logic [fsrr_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [fsrr_pkg::DVS_W-1:0]  dvs_r;
  logic [fsrr_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic [fsrr_pkg::DVS_W:0]    rem_sh;
  logic [fsrr_pkg::DVS_W:0]    rem_diff;

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r, q_r[fsrr_pkg::DVD_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_diff[fsrr_pkg::DVS_W-1:0];
        q_nxt   = {q_r[fsrr_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[fsrr_pkg::DVS_W-1:0];
        q_nxt   = {q_r[fsrr_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == fsrr_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ===== hw/rtl/fsrr_datapath.sv =====
// ----------------------------------------------------------------------------
// fsrr_datapath
// Operand registers, series accumulator, row sum and output register, with
// the shared multiplier and divider.
// ----------------------------------------------------------------------------
module fsrr_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fsrr_pkg::cmd_t                cmd,
  output fsrr_pkg::stat_t               stat,
  input  logic [79:0]                   in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fsrr_pkg::OUT_W-1:0]    out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  // clamp a fitness value to +-20
  function automatic logic signed [fsrr_pkg::CFIT_W-1:0] clamp_fit(
    input logic signed [fsrr_pkg::FIT_W-1:0] v
  );
    logic signed [fsrr_pkg::CFIT_W-1:0] r;
    if (v > fsrr_pkg::FIT_W'(fsrr_pkg::FIT_LIMIT)) begin
      r = fsrr_pkg::FIT_LIMIT;
    end else if (v < -fsrr_pkg::FIT_W'(fsrr_pkg::FIT_LIMIT)) begin
      r = -fsrr_pkg::FIT_LIMIT;
    end else begin
      r = v[fsrr_pkg::CFIT_W-1:0];
    end
    return r;
  endfunction

  logic [fsrr_pkg::RATE_W-1:0]         rate_r;
  logic signed [fsrr_pkg::CFIT_W-1:0]  fs_r, ft_r;
  logic                                end_r;
  logic signed [fsrr_pkg::S_W-1:0]     s_r, s_comb;
  logic [fsrr_pkg::X_W-1:0]            x_r, x_comb;
  logic [fsrr_pkg::K_W-1:0]            k_r;
  logic [fsrr_pkg::F_W-1:0]            f_r, z_r;
  logic [fsrr_pkg::Q32_W-1:0]          term_r, term_new;
  logic signed [fsrr_pkg::ACC_W-1:0]   acc_r;
  logic [fsrr_pkg::N_W-1:0]            n_r;
  logic [fsrr_pkg::MUL_W-1:0]          recip_comb;
  logic [fsrr_pkg::RSH_W-1:0]          rsh_comb;
  logic [fsrr_pkg::Q32_W-1:0]          u_r, d_r, p_comb, u_comb;
  logic [fsrr_pkg::G_W-1:0]            g_r, g_small;
  logic signed [fsrr_pkg::G_W-1:0]     s_ext;
  logic [fsrr_pkg::E_W-1:0]            e_r, e_comb;
  logic [fsrr_pkg::SUM_W-1:0]          sum_r;
  logic [fsrr_pkg::SUM_W:0]            sum_wide;
  logic [fsrr_pkg::PROD_W-1:0]         rounded;
  logic                                small_comb;

  logic [fsrr_pkg::MUL_W-1:0]          mul_a, mul_b;
  logic [fsrr_pkg::PROD_W-1:0]         prod_r;

  logic [fsrr_pkg::DVD_W-1:0]          div_dvd;
  logic [fsrr_pkg::DVS_W-1:0]          div_dvs;
  logic [fsrr_pkg::STEP_W-1:0]         div_steps;
  logic                                div_busy;
  logic [fsrr_pkg::DVD_W-1:0]          div_q;

  logic                                out_valid_r;
  logic [fsrr_pkg::OUT_W-1:0]          out_data_r;
  logic                                out_user_r, out_last_r;

  // difference and small-argument series
  always_comb begin
    s_comb     = fsrr_pkg::S_W'(ft_r) - fsrr_pkg::S_W'(fs_r);
    x_comb     = s_comb[fsrr_pkg::S_W-1] ? fsrr_pkg::X_W'(-s_comb)
                                         : fsrr_pkg::X_W'(s_comb);
    small_comb = (s_comb >= -fsrr_pkg::SMALL_S) && (s_comb <= fsrr_pkg::SMALL_S);
    s_ext      = fsrr_pkg::G_W'(s_comb);
    g_small    = fsrr_pkg::ONE_Q24 + fsrr_pkg::G_W'(s_ext <<< 7);
  end

  // reciprocal of the term index, ceil(2^shift / n), exact floor for 32-bit terms
  always_comb begin
    case (n_r)
      4'd1: begin
        recip_comb = 33'd4294967296;
        rsh_comb   = 6'd32;
      end
      4'd2: begin
        recip_comb = 33'd4294967296;
        rsh_comb   = 6'd33;
      end
      4'd3: begin
        recip_comb = 33'd5726623062;
        rsh_comb   = 6'd34;
      end
      4'd4: begin
        recip_comb = 33'd4294967296;
        rsh_comb   = 6'd34;
      end
      4'd5: begin
        recip_comb = 33'd6871947674;
        rsh_comb   = 6'd35;
      end
      4'd6: begin
        recip_comb = 33'd5726623062;
        rsh_comb   = 6'd35;
      end
      4'd7: begin
        recip_comb = 33'd4908534053;
        rsh_comb   = 6'd35;
      end
      4'd8: begin
        recip_comb = 33'd4294967296;
        rsh_comb   = 6'd35;
      end
      4'd9: begin
        recip_comb = 33'd7635497416;
        rsh_comb   = 6'd36;
      end
      4'd10: begin
        recip_comb = 33'd6871947674;
        rsh_comb   = 6'd36;
      end
      4'd11: begin
        recip_comb = 33'd6247225158;
        rsh_comb   = 6'd36;
      end
      default: begin
        recip_comb = '0;
        rsh_comb   = 6'd32;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      fsrr_pkg::MUL_X_LOG2E: begin
        mul_a = fsrr_pkg::MUL_W'(x_r);
        mul_b = fsrr_pkg::LOG2E_Q30;
      end
      fsrr_pkg::MUL_F_LN2: begin
        mul_a = fsrr_pkg::MUL_W'(f_r);
        mul_b = fsrr_pkg::LN2_Q32;
      end
      fsrr_pkg::MUL_T_Z: begin
        mul_a = term_r;
        mul_b = fsrr_pkg::MUL_W'(z_r);
      end
      fsrr_pkg::MUL_T_RECIP: begin
        mul_a = fsrr_pkg::MUL_W'(prod_r[63:32]);
        mul_b = recip_comb;
      end
      fsrr_pkg::MUL_X_U: begin
        mul_a = fsrr_pkg::MUL_W'(x_r);
        mul_b = u_r;
      end
      fsrr_pkg::MUL_R_G: begin
        mul_a = fsrr_pkg::MUL_W'(rate_r);
        mul_b = fsrr_pkg::MUL_W'(g_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fsrr_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // divider job select
  always_comb begin
    case (cmd.div_kind)
      fsrr_pkg::DIV_POS: begin
        div_dvd   = {x_r, 42'd0};
        div_dvs   = d_r;
        div_steps = fsrr_pkg::G_STEPS;
      end
      fsrr_pkg::DIV_NEG: begin
        div_dvd   = {prod_r[53:0], 10'd0};
        div_dvs   = d_r;
        div_steps = fsrr_pkg::G_STEPS;
      end
      default: begin
        div_dvd   = '0;
        div_dvs   = fsrr_pkg::DVS_W'(1);
        div_steps = fsrr_pkg::G_STEPS;
      end
    endcase
  end

  fsrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // exp(-x) and denominator, entry rounding and saturating sum
  always_comb begin
    term_new = fsrr_pkg::Q32_W'(prod_r >> rsh_comb);
    p_comb   = acc_r[fsrr_pkg::ACC_W-1] ? '0 : acc_r[fsrr_pkg::Q32_W-1:0];
    u_comb   = (k_r >= fsrr_pkg::K_ZERO) ? '0 : (p_comb >> k_r);
    rounded  = prod_r + fsrr_pkg::ROUND_Q24;
    e_comb   = rounded[63:24];
    sum_wide = {1'b0, sum_r} + (fsrr_pkg::SUM_W + 1)'(e_comb);
  end

  // operand and series registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      rate_r <= in_tdata[31:0];
      fs_r   <= clamp_fit(in_tdata[55:32]);
      ft_r   <= clamp_fit(in_tdata[79:56]);
      end_r  <= in_tlast;
    end
    if (cmd.ld_diff) begin
      s_r <= s_comb;
      x_r <= x_comb;
      g_r <= g_small;
    end
    if (cmd.ld_yk) begin
      k_r <= prod_r[52:46];
      f_r <= prod_r[45:14];
    end
    if (cmd.ld_z) begin
      z_r    <= prod_r[63:32];
      term_r <= fsrr_pkg::ONE_Q32;
      acc_r  <= fsrr_pkg::ACC_W'(fsrr_pkg::ONE_Q32);
      n_r    <= fsrr_pkg::N_W'(1);
    end
    if (cmd.ld_term) begin
      term_r <= term_new;
      if (n_r[0]) begin
        acc_r <= acc_r - fsrr_pkg::ACC_W'(term_new);
      end else begin
        acc_r <= acc_r + fsrr_pkg::ACC_W'(term_new);
      end
      n_r <= n_r + 1'b1;
    end
    if (cmd.ld_u) begin
      u_r <= u_comb;
      d_r <= (u_comb >= fsrr_pkg::ONE_Q32) ? fsrr_pkg::Q32_W'(1)
                                           : fsrr_pkg::ONE_Q32 - u_comb;
    end
    if (cmd.ld_g) begin
      g_r <= div_q[fsrr_pkg::G_W-1:0];
    end
    if (cmd.ld_e) begin
      e_r <= e_comb;
    end
  end

  // row sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.ld_e) begin
      sum_r <= sum_wide[fsrr_pkg::SUM_W] || (sum_wide[fsrr_pkg::SUM_W-1:0] > fsrr_pkg::SUM_MAX)
               ? fsrr_pkg::SUM_MAX : sum_wide[fsrr_pkg::SUM_W-1:0];
    end else if (cmd.emit_d) begin
      sum_r <= '0;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_e || cmd.emit_d) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit_e) begin
      out_data_r <= fsrr_pkg::OUT_W'(e_r);
      out_user_r <= 1'b0;
      out_last_r <= ~end_r;
    end else if (cmd.emit_d) begin
      out_data_r <= '0 - sum_r;
      out_user_r <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // status to the controller
  always_comb begin
    stat.near_zero = small_comb;
    stat.s_pos     = ~s_r[fsrr_pkg::S_W-1];
    stat.n_last    = (n_r == fsrr_pkg::N_TERMS);
    stat.row_end   = end_r;
    stat.div_busy  = div_busy;
    stat.out_free  = ~out_valid_r | out_tready;
  end

endmodule

// ===== hw/rtl/fsrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsrr_ctrl
// Sequencer for one entry: clamp and difference, exponential by range
// reduction and series, fixation factor division, scaling, result issue.
// ----------------------------------------------------------------------------
module fsrr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  fsrr_pkg::stat_t  stat,
  output fsrr_pkg::cmd_t   cmd
);

  fsrr_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsrr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.mul_sel  = fsrr_pkg::MUL_X_LOG2E;
    cmd.div_kind = fsrr_pkg::DIV_POS;
    in_tready    = 1'b0;
    case (state_r)
      fsrr_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.ld_in  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = fsrr_pkg::ST_DIFF;
        end
      end
      fsrr_pkg::ST_DIFF: begin
        cmd.ld_diff = 1'b1;
        state_nxt   = stat.near_zero ? fsrr_pkg::ST_RMUL : fsrr_pkg::ST_YMUL;
      end
      fsrr_pkg::ST_YMUL: begin
        cmd.mul_sel = fsrr_pkg::MUL_X_LOG2E;
        state_nxt   = fsrr_pkg::ST_YGET;
      end
      fsrr_pkg::ST_YGET: begin
        cmd.ld_yk = 1'b1;
        state_nxt = fsrr_pkg::ST_ZMUL;
      end
      fsrr_pkg::ST_ZMUL: begin
        cmd.mul_sel = fsrr_pkg::MUL_F_LN2;
        state_nxt   = fsrr_pkg::ST_ZGET;
      end
      fsrr_pkg::ST_ZGET: begin
        cmd.ld_z  = 1'b1;
        state_nxt = fsrr_pkg::ST_TMUL;
      end
      fsrr_pkg::ST_TMUL: begin
        cmd.mul_sel = fsrr_pkg::MUL_T_Z;
        state_nxt   = fsrr_pkg::ST_TREC;
      end
      // divide the term by its index through the reciprocal
      fsrr_pkg::ST_TREC: begin
        cmd.mul_sel = fsrr_pkg::MUL_T_RECIP;
        state_nxt   = fsrr_pkg::ST_TGET;
      end
      fsrr_pkg::ST_TGET: begin
        cmd.ld_term = 1'b1;
        state_nxt   = stat.n_last ? fsrr_pkg::ST_UCALC : fsrr_pkg::ST_TMUL;
      end
      fsrr_pkg::ST_UCALC: begin
        cmd.ld_u  = 1'b1;
        state_nxt = stat.s_pos ? fsrr_pkg::ST_GDIV : fsrr_pkg::ST_XUMUL;
      end
      fsrr_pkg::ST_XUMUL: begin
        cmd.mul_sel = fsrr_pkg::MUL_X_U;
        state_nxt   = fsrr_pkg::ST_GDIV;
      end
      fsrr_pkg::ST_GDIV: begin
        cmd.div_go   = 1'b1;
        cmd.div_kind = stat.s_pos ? fsrr_pkg::DIV_POS : fsrr_pkg::DIV_NEG;
        state_nxt    = fsrr_pkg::ST_GWAIT;
      end
      fsrr_pkg::ST_GWAIT: begin
        if (!stat.div_busy) begin
          cmd.ld_g  = 1'b1;
          state_nxt = fsrr_pkg::ST_RMUL;
        end
      end
      fsrr_pkg::ST_RMUL: begin
        cmd.mul_sel = fsrr_pkg::MUL_R_G;
        state_nxt   = fsrr_pkg::ST_EGET;
      end
      fsrr_pkg::ST_EGET: begin
        cmd.ld_e  = 1'b1;
        state_nxt = fsrr_pkg::ST_EMIT_E;
      end
      fsrr_pkg::ST_EMIT_E: begin
        if (stat.out_free) begin
          cmd.emit_e = 1'b1;
          state_nxt  = stat.row_end ? fsrr_pkg::ST_EMIT_D : fsrr_pkg::ST_IDLE;
        end
      end
      fsrr_pkg::ST_EMIT_D: begin
        if (stat.out_free) begin
          cmd.emit_d = 1'b1;
          state_nxt  = fsrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fsrr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fixation_scaled_rate_row.sv =====
// ----------------------------------------------------------------------------
// fixation_scaled_rate_row
// Scales off-diagonal rate-matrix entries by the fixation factor
// S/(1-exp(-S)) and closes each row with its diagonal.
//
// Input channel: one off-diagonal entry per transfer; tlast marks the last
// entry of a row. Output channel: one result per entry, and on a row end a
// second result, the diagonal (minus the saturated row sum), flagged in
// tuser. out_tlast marks the final result caused by an input transfer.
// One entry is handled at a time. An entry with |S| of at most six LSB
// takes a short path that skips the exponential and the division. Any
// other entry goes through range reduction and the eleven-term exponential
// series, whose divisions by the term index use reciprocal multiplication,
// then the bit-serial divider that forms the 62-bit fixation factor
// quotient, with one more multiplication before it when S is negative.
// The next entry is taken only once the last result of the previous one
// has been placed in the output register.
// Reset clears the row sum, the sequencer and the output valid.
// When the receiver stalls, a result waits in the output register; the
// sequencer holds before issuing a further result until it drains.
// ----------------------------------------------------------------------------
module fixation_scaled_rate_row (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,    // base_rate[31:0], fitness_source[55:32],
                                   // fitness_target[79:56]
  input  logic        in_tlast,    // row_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // scaled_rate[47:0]
  output logic        out_tuser,   // diagonal_flag
  output logic        out_tlast    // last
);

  fsrr_pkg::cmd_t  cmd;
  fsrr_pkg::stat_t stat;

  fsrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fsrr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
